@@ sv/vca_pkg.sv @@
// Package for the polyphonic voice allocator.
// Holds the command codes, the request and result payloads, the sequencer states
// and the control groups. It depends on nothing else.
package vca_pkg;

  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned VIDX_W    = 3;
  localparam int unsigned RELEASE_W = 8;

  localparam logic [CMD_W-1:0] CMD_NOTE_ON    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_VOICE_DONE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NOTE_W-1:0] note_number;
    logic [NOTE_W-1:0] note_velocity;
    logic [VIDX_W-1:0] done_voice;
  } event_t;

  typedef struct packed {
    logic [VIDX_W-1:0]    assigned_voice;
    logic                 stolen;
    logic [RELEASE_W-1:0] release_mask;
    logic [NOTE_W-1:0]    start_note;
    logic [NOTE_W-1:0]    start_velocity;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctrl_t;

  typedef struct packed {
    logic load;
    logic clear;
  } tbl_ctrl_t;

endpackage

@@ sv/vca_if.sv @@
// Handshake channels of the voice allocator: one for incoming events, one for results.
// Each carries valid, ready and a payload struct; depends on vca_pkg.
interface vca_event_if;
  import vca_pkg::*;
  logic   valid;
  logic   ready;
  event_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface vca_result_if;
  import vca_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/vca_table.sv @@
// Voice table: busy marks, held notes and start ages, one read port and one write port.
// Depends on vca_pkg for the control group.
module vca_table
  import vca_pkg::*;
#(
  parameter int unsigned VOICE_COUNT = 8,
  parameter int unsigned AGE_BITS    = 32,
  localparam int unsigned VIDX = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tbl_ctrl_t              ctrl,
  input  logic [VIDX-1:0]        wr_idx,
  input  logic [NOTE_W-1:0]      wr_key,
  input  logic [AGE_BITS-1:0]    wr_age,
  input  logic [VIDX-1:0]        rd_idx,
  output logic                   rd_busy,
  output logic [NOTE_W-1:0]      rd_key,
  output logic [AGE_BITS-1:0]    rd_age,
  output logic [VOICE_COUNT-1:0] busy
);

  logic [NOTE_W-1:0]   key [VOICE_COUNT];
  logic [AGE_BITS-1:0] age [VOICE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (ctrl.load) begin
      busy[wr_idx] <= 1'b1;
    end else if (ctrl.clear) begin
      busy[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key[wr_idx] <= wr_key;
      age[wr_idx] <= wr_age;
    end
  end

  assign rd_busy = busy[rd_idx];
  assign rd_key  = key[rd_idx];
  assign rd_age  = age[rd_idx];

endmodule

@@ sv/vca_scan.sv @@
// Shared compare unit: looks at one voice per cycle and keeps the first free voice,
// the voice with the smallest age and the note-off release mask. Depends on vca_pkg.
module vca_scan
  import vca_pkg::*;
#(
  parameter int unsigned VOICE_COUNT = 8,
  parameter int unsigned AGE_BITS    = 32,
  localparam int unsigned VIDX = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scan_ctrl_t           ctrl,
  input  logic [VIDX-1:0]      idx,
  input  logic                 busy,
  input  logic [NOTE_W-1:0]    key,
  input  logic [AGE_BITS-1:0]  age,
  input  logic [NOTE_W-1:0]    note,
  output logic                 free_found,
  output logic [VIDX-1:0]      free_idx,
  output logic [VIDX-1:0]      min_idx,
  output logic [RELEASE_W-1:0] mask
);

  logic [AGE_BITS-1:0] min_age;
  logic                in_mask;

  assign in_mask = (32'(idx) < RELEASE_W) && busy && (key == note);

  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      free_found <= 1'b0;
      mask       <= '0;
    end else if (ctrl.step) begin
      if (!busy) begin
        free_found <= 1'b1;
      end
      if (in_mask) begin
        mask <= mask | (RELEASE_W'(1) << idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      if (!busy && !free_found) begin
        free_idx <= idx;
      end
      if ((idx == '0) || (age < min_age)) begin
        min_idx <= idx;
        min_age <= age;
      end
    end
  end

endmodule

@@ sv/polyphonic_voice_allocator.sv @@
// Polyphonic voice allocator with oldest-voice stealing; uses vca_pkg, vca_if,
// vca_table and vca_scan. A note-on or note-off is accepted in IDLE, then the scan visits
// one voice per cycle in SCAN, then APPLY updates the table and EMIT registers the result;
// EMIT waits while results are stalled, and the next request is taken only back in IDLE.
// Voice-done and unused commands skip the scan and go straight from IDLE to APPLY and EMIT.
// Synchronous reset clears all busy marks, the age counter and the result valid flag.
module polyphonic_voice_allocator
  import vca_pkg::*;
#(
  parameter int unsigned VOICE_COUNT = 8,
  parameter int unsigned AGE_BITS    = 32
) (
  input logic          clk,
  input logic          rst,
  vca_event_if.sink    event_ch,
  vca_result_if.source result_ch
);

  localparam int unsigned VIDX = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VIDX-1:0] LAST_VOICE = VIDX'(VOICE_COUNT - 1);

  state_t               state;
  state_t               state_next;
  event_t               cmd_q;
  logic [VIDX-1:0]      scan_idx;
  logic [AGE_BITS-1:0]  age_counter;
  result_t              res;
  result_t              res_next;
  logic                 out_valid;
  logic                 emit;
  logic                 accept;
  scan_ctrl_t           scan_ctrl;
  tbl_ctrl_t            tbl_ctrl;
  logic [VIDX-1:0]      wr_idx;
  logic                 rd_busy;
  logic [NOTE_W-1:0]    rd_key;
  logic [AGE_BITS-1:0]  rd_age;
  logic [VOICE_COUNT-1:0] busy;
  logic                 free_found;
  logic [VIDX-1:0]      free_idx;
  logic [VIDX-1:0]      min_idx;
  logic [RELEASE_W-1:0] mask;
  logic [VIDX-1:0]      pick;

  assign event_ch.ready    = (state == ST_IDLE);
  assign accept            = event_ch.valid && event_ch.ready;
  assign result_ch.valid   = out_valid;
  assign result_ch.payload = res;
  assign pick              = free_found ? free_idx : min_idx;

  vca_table #(
    .VOICE_COUNT(VOICE_COUNT),
    .AGE_BITS   (AGE_BITS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (tbl_ctrl),
    .wr_idx (wr_idx),
    .wr_key (cmd_q.note_number),
    .wr_age (age_counter),
    .rd_idx (scan_idx),
    .rd_busy(rd_busy),
    .rd_key (rd_key),
    .rd_age (rd_age),
    .busy   (busy)
  );

  vca_scan #(
    .VOICE_COUNT(VOICE_COUNT),
    .AGE_BITS   (AGE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (scan_ctrl),
    .idx       (scan_idx),
    .busy      (rd_busy),
    .key       (rd_key),
    .age       (rd_age),
    .note      (cmd_q.note_number),
    .free_found(free_found),
    .free_idx  (free_idx),
    .min_idx   (min_idx),
    .mask      (mask)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    scan_ctrl       = '0;
    tbl_ctrl        = '0;
    wr_idx          = pick;
    emit            = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          scan_ctrl.start = 1'b1;
          if (event_ch.payload.command == CMD_NOTE_ON ||
              event_ch.payload.command == CMD_NOTE_OFF) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (scan_idx == LAST_VOICE) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (cmd_q.command == CMD_NOTE_ON) begin
          tbl_ctrl.load = 1'b1;
        end else if (cmd_q.command == CMD_VOICE_DONE &&
                     32'(cmd_q.done_voice) < VOICE_COUNT) begin
          tbl_ctrl.clear = 1'b1;
          wr_idx         = VIDX'(cmd_q.done_voice);
        end
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || result_ch.ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_next = '0;
    case (cmd_q.command)
      CMD_NOTE_ON: begin
        res_next.assigned_voice = VIDX_W'(pick);
        res_next.stolen         = !free_found;
        res_next.start_note     = cmd_q.note_number;
        res_next.start_velocity = cmd_q.note_velocity;
      end
      CMD_NOTE_OFF: begin
        res_next.release_mask = mask;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= event_ch.payload;
    end
    if (emit) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || accept) begin
      scan_idx <= '0;
    end else if (scan_ctrl.step && scan_idx != LAST_VOICE) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_counter <= '0;
    end else if (tbl_ctrl.load) begin
      age_counter <= age_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("allocator accepted a request but stayed idle");

  a_age_advance: assert property (@(posedge clk) disable iff (rst)
    tbl_ctrl.load |=> age_counter == AGE_BITS'($past(age_counter) + 1'b1))
    else $error("age counter did not advance on a voice assignment");

  a_steal_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (tbl_ctrl.load && !free_found) |-> (&busy))
    else $error("voice stolen while a free voice existed");

  a_load_marks_busy: assert property (@(posedge clk) disable iff (rst)
    tbl_ctrl.load |=> busy[$past(wr_idx)])
    else $error("assigned voice not marked busy");

  a_mask_only_note_off: assert property (@(posedge clk) disable iff (rst)
    (emit && cmd_q.command != CMD_NOTE_OFF) |=> res.release_mask == '0)
    else $error("release mask set for a command other than note off");

endmodule

@@ verif/tb_polyphonic_voice_allocator.sv @@
// Self-checking testbench for the polyphonic voice allocator: directed and random requests
// go through a queue-fed driver, and a predictor of the voice table checks every result.
// Depends on vca_pkg, vca_if and the polyphonic_voice_allocator RTL.
module tb_polyphonic_voice_allocator;
  import vca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VOICES = 8;
  localparam int unsigned AGE_W  = 32;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst;

  vca_event_if  request_ch ();
  vca_result_if result_ch ();

  polyphonic_voice_allocator #(
    .VOICE_COUNT(VOICES),
    .AGE_BITS(AGE_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .event_ch(request_ch),
    .result_ch(result_ch)
  );

  event_t  pending_requests[$];
  result_t due_results[$];
  int      issued_count;
  int      accepted_count;
  int      mismatch_count;
  int      send_idle_pct;
  int      recv_stall_pct;

  logic             voice_busy [VOICES];
  logic [NOTE_W-1:0] voice_key [VOICES];
  logic [NOTE_W-1:0] voice_level [VOICES];
  logic [AGE_W-1:0]  voice_age [VOICES];
  logic [AGE_W-1:0]  age_counter;

  // Applies one request to the model voice table and returns the result it should give.
  function automatic result_t allocate_voice(event_t req);
    result_t res;
    int      pick;
    bit      found;
    res = '0;
    pick = 0;
    found = 1'b0;
    case (req.command)
      CMD_NOTE_ON: begin
        for (int i = 0; i < VOICES; i++) begin
          if (!found && !voice_busy[i]) begin
            pick = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          for (int i = 1; i < VOICES; i++) begin
            if (voice_age[i] < voice_age[pick]) pick = i;
          end
          res.stolen = 1'b1;
        end
        voice_busy[pick] = 1'b1;
        voice_key[pick] = req.note_number;
        voice_level[pick] = req.note_velocity;
        voice_age[pick] = age_counter;
        age_counter = age_counter + 1'b1;
        res.assigned_voice = VIDX_W'(pick);
        res.start_note = req.note_number;
        res.start_velocity = req.note_velocity;
      end
      CMD_NOTE_OFF: begin
        for (int i = 0; i < VOICES && i < RELEASE_W; i++) begin
          if (voice_busy[i] && voice_key[i] == req.note_number) res.release_mask[i] = 1'b1;
        end
      end
      CMD_VOICE_DONE: begin
        if (req.done_voice < VOICES) voice_busy[req.done_voice] = 1'b0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic queue_request(logic [CMD_W-1:0] cmd, int note, int vel, int voice);
    event_t req;
    req.command = cmd;
    req.note_number = NOTE_W'(note);
    req.note_velocity = NOTE_W'(vel);
    req.done_voice = VIDX_W'(voice);
    pending_requests.push_back(req);
    issued_count++;
  endtask

  // Mostly well-formed traffic; a narrow band of notes makes note-offs hit held voices.
  task automatic queue_random_request();
    int pick;
    int note;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 40) cmd = CMD_NOTE_ON;
    else if (pick < 65) cmd = CMD_NOTE_OFF;
    else if (pick < 95) cmd = CMD_VOICE_DONE;
    else cmd = CMD_UNUSED;
    note = ($urandom_range(99) < 60) ? $urandom_range(67, 60) : $urandom_range(127);
    queue_request(cmd, note, $urandom_range(127), $urandom_range(7));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      request_ch.valid <= 1'b0;
    end else begin
      if (request_ch.valid && request_ch.ready) begin
        due_results.push_back(allocate_voice(request_ch.payload));
        accepted_count++;
      end
      if (!request_ch.valid || request_ch.ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          request_ch.valid <= 1'b1;
          request_ch.payload <= pending_requests.pop_front();
        end else begin
          request_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result at %0t: %p", $realtime, result_ch.payload);
        end else begin
          want = due_results.pop_front();
          if (result_ch.payload.assigned_voice !== want.assigned_voice ||
              result_ch.payload.stolen !== want.stolen ||
              result_ch.payload.release_mask !== want.release_mask ||
              result_ch.payload.start_note !== want.start_note ||
              result_ch.payload.start_velocity !== want.start_velocity) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch at %0t: expected %p, got %p", $realtime, want,
                       result_ch.payload);
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    rst = 1'b1;
    request_ch.valid = 1'b0;
    request_ch.payload = '0;
    result_ch.ready = 1'b0;
    issued_count = 0;
    accepted_count = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    age_counter = '0;
    for (int i = 0; i < VOICES; i++) begin
      voice_busy[i] = 1'b0;
      voice_key[i] = '0;
      voice_level[i] = '0;
      voice_age[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Fill the table with extreme and repeated notes, then release, steal and free voices.
    queue_request(CMD_NOTE_ON, 0, 0, 0);
    queue_request(CMD_NOTE_ON, 127, 127, 7);
    queue_request(CMD_NOTE_ON, 60, 1, 0);
    queue_request(CMD_NOTE_ON, 60, 64, 0);
    queue_request(CMD_NOTE_ON, 60, 126, 0);
    queue_request(CMD_NOTE_ON, 64, 85, 0);
    queue_request(CMD_NOTE_ON, 64, 42, 0);
    queue_request(CMD_NOTE_ON, 127, 0, 0);
    queue_request(CMD_NOTE_OFF, 60, 0, 0);
    queue_request(CMD_NOTE_OFF, 127, 127, 7);
    queue_request(CMD_NOTE_OFF, 5, 0, 0);
    queue_request(CMD_NOTE_ON, 72, 100, 0);
    queue_request(CMD_NOTE_ON, 73, 101, 0);
    queue_request(CMD_VOICE_DONE, 0, 0, 3);
    queue_request(CMD_NOTE_ON, 74, 102, 0);
    queue_request(CMD_VOICE_DONE, 0, 0, 7);
    queue_request(CMD_VOICE_DONE, 0, 0, 7);
    queue_request(CMD_NOTE_OFF, 127, 0, 0);
    queue_request(CMD_UNUSED, 127, 127, 7);
    queue_request(CMD_VOICE_DONE, 127, 127, 0);
    queue_request(CMD_NOTE_ON, 0, 127, 7);
    queue_request(CMD_NOTE_OFF, 0, 0, 0);
    queue_request(CMD_NOTE_ON, 99, 55, 0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      repeat (385) queue_random_request();
      wait (pending_requests.size() == 0);
    end

    wait (accepted_count == issued_count && due_results.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
